// ===== src/periodic_boundary_wrap_assert.svh =====
// assertion macros for the boundary wrap block
`ifndef PERIODIC_BOUNDARY_WRAP_ASSERT_SVH
`define PERIODIC_BOUNDARY_WRAP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PBW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pbw_pkg.sv =====
// shared types and constants of the boundary wrap block
package pbw_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int LEN_W       = 31;
    // dividend width of the divider: x minus shear times image count
    localparam int DIV_W       = 66;
    localparam int CNT_W       = COORD_WIDTH + 1;
    localparam int PROD_W      = COORD_WIDTH + CNT_W;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        BC_PERIODIC  = 2'd0,
        BC_XPERIODIC = 2'd1,
        BC_SHEAR     = 2'd2,
        BC_OPEN      = 2'd3
    } bc_mode_t;

    typedef enum logic {
        OP_DISP = 1'b0,
        OP_POS  = 1'b1
    } opcode_t;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_SHEAR  = 2'd3;

    localparam logic [LEN_W-1:0] BOX_RESET = LEN_W'(65536);

    typedef struct packed {
        bc_mode_t                 bc_mode;
        logic [LEN_W-1:0]         box_width;
        logic [LEN_W-1:0]         box_height;
        logic signed [DATA_W-1:0] shear_offset;
    } cfg_t;

    // word context that rides alongside the dividers
    typedef struct packed {
        logic                          opcode;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] ymin;
    } side_t;

endpackage

// ===== src/pbw_in_if.sv =====
// input channel: one vector word per handshake
interface pbw_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   opcode;
    logic signed [pbw_pkg::COORD_WIDTH-1:0] x_in;
    logic signed [pbw_pkg::COORD_WIDTH-1:0] y_in;

    modport source (output valid, opcode, x_in, y_in, input ready);
    modport sink (input valid, opcode, x_in, y_in, output ready);
endinterface

// ===== src/pbw_out_if.sv =====
// output channel: one wrapped vector word per handshake
interface pbw_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pbw_pkg::COORD_WIDTH-1:0] x_out;
    logic signed [pbw_pkg::COORD_WIDTH-1:0] y_out;
    logic                                   status;

    modport source (output valid, x_out, y_out, status, input ready);
    modport sink (input valid, x_out, y_out, status, output ready);
endinterface

// ===== src/pbw_fdiv.sv =====
// pipelined floor division, one quotient bit per stage
module pbw_fdiv
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              vin,
    input  logic signed [pbw_pkg::DIV_W-1:0]  dividend,
    input  logic [pbw_pkg::LEN_W-1:0]         len,
    input  pbw_pkg::side_t                    side_in,
    output logic                              vout,
    output logic [pbw_pkg::LEN_W-1:0]         rem,
    output logic signed [pbw_pkg::DIV_W-1:0]  quo,
    output pbw_pkg::side_t                    side_out
);

    localparam int DW = pbw_pkg::DIV_W;
    localparam int LW = pbw_pkg::LEN_W;

    logic                 vld_reg  [DW+1];
    logic                 neg_reg  [DW+1];
    logic [LW-1:0]        rem_reg  [DW+1];
    logic [DW-1:0]        work_reg [DW+1];
    pbw_pkg::side_t       side_reg [DW+1];

    logic                 vout_reg;
    logic [LW-1:0]        rem_out_reg;
    logic signed [DW-1:0] quo_out_reg;
    pbw_pkg::side_t       side_out_reg;

    logic [LW-1:0]        u;
    logic [DW-1:0]        qm;
    logic                 nz;
    logic [LW-1:0]        rem_next;
    logic signed [DW-1:0] quo_next;

    // entry stage: sign and magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= dividend[DW-1];
            rem_reg[0]  <= '0;
            work_reg[0] <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            side_reg[0] <= side_in;
        end
    end

    // restoring steps, msb first
    for (genvar k = 1; k <= DW; k++)
    begin : g_step
        logic [LW:0]   t;
        logic          ge;
        logic [LW:0]   diff;

        assign t    = {rem_reg[k-1], work_reg[k-1][DW-1]};
        assign ge   = t >= {1'b0, len};
        assign diff = t - {1'b0, len};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k]  <= neg_reg[k-1];
                rem_reg[k]  <= ge ? diff[LW-1:0] : t[LW-1:0];
                work_reg[k] <= {work_reg[k-1][DW-2:0], ge};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // fold the sign back in for a floor result
    assign u  = rem_reg[DW];
    assign qm = work_reg[DW];
    assign nz = |u;

    always_comb
    begin
        if (neg_reg[DW])
        begin
            rem_next = nz ? len - u : '0;
            quo_next = -$signed(qm) - $signed(DW'(nz));
        end
        else
        begin
            rem_next = u;
            quo_next = $signed(qm);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else if (en)
        begin
            vout_reg <= vld_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out_reg  <= rem_next;
            quo_out_reg  <= quo_next;
            side_out_reg <= side_reg[DW];
        end
    end

    assign vout     = vout_reg;
    assign rem      = rem_out_reg;
    assign quo      = quo_out_reg;
    assign side_out = side_out_reg;

endmodule

// ===== src/pbw_apb_regs.sv =====
// apb register file of the boundary wrap block
module pbw_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbw_pkg::ADDR_W-1:0]    paddr,
    input  logic [pbw_pkg::DATA_W-1:0]    pwdata,
    output logic [pbw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output pbw_pkg::cfg_t                 cfg
);

    pbw_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bc_mode      <= pbw_pkg::BC_PERIODIC;
            cfg_reg.box_width    <= pbw_pkg::BOX_RESET;
            cfg_reg.box_height   <= pbw_pkg::BOX_RESET;
            cfg_reg.shear_offset <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                pbw_pkg::REG_MODE:   cfg_reg.bc_mode <= pbw_pkg::bc_mode_t'(pwdata[1:0]);
                pbw_pkg::REG_WIDTH:  cfg_reg.box_width <= pwdata[pbw_pkg::LEN_W-1:0];
                pbw_pkg::REG_HEIGHT: cfg_reg.box_height <= pwdata[pbw_pkg::LEN_W-1:0];
                pbw_pkg::REG_SHEAR:  cfg_reg.shear_offset <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pbw_pkg::REG_MODE:   prdata = {30'd0, cfg_reg.bc_mode};
            pbw_pkg::REG_WIDTH:  prdata = {1'b0, cfg_reg.box_width};
            pbw_pkg::REG_HEIGHT: prdata = {1'b0, cfg_reg.box_height};
            pbw_pkg::REG_SHEAR:  prdata = cfg_reg.shear_offset;
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/periodic_boundary_wrap.sv =====
// top level of the 2-d box boundary wrap block
// Wraps one Q16.16 vector word per cycle by the box boundary conditions: the
// y coordinate goes through a bit-per-stage floor divider, then the
// Lees-Edwards image shift of x is formed (one 32x33 multiply and a subtract),
// then a second bit-per-stage divider reduces x. Each divider is 68 registers
// deep (an entry stage, 66 one-bit steps and an output register), the shift
// arithmetic takes three stages and the output register one, 140 registers in
// all with the first loaded at the handshake edge. A new word is taken every
// cycle unless a finished word waits at the output, and then the whole
// pipeline holds. Configuration registers sit on the apb port: bc_mode at
// 0x0, box_width at 0x4, box_height at 0x8, shear_offset at 0xc; write them
// only while no word is in flight.
module periodic_boundary_wrap
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbw_pkg::ADDR_W-1:0]    paddr,
    input  logic [pbw_pkg::DATA_W-1:0]    pwdata,
    output logic [pbw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    pbw_in_if.sink                        din,
    pbw_out_if.source                     dout
);

    localparam int CW = pbw_pkg::COORD_WIDTH;
    localparam int LW = pbw_pkg::LEN_W;
    localparam int DW = pbw_pkg::DIV_W;
    localparam int NW = pbw_pkg::CNT_W;
    localparam int PW = pbw_pkg::PROD_W;

    pbw_pkg::cfg_t cfg;

    // whole pipeline moves unless the output word is stalled
    logic en;

    // effective box sizes, zero acts as one
    logic [LW-1:0] lx;
    logic [LW-1:0] ly;

    pbw_pkg::side_t        side_in;
    logic                  yv;
    logic [LW-1:0]         ry;
    logic signed [DW-1:0]  qy;
    pbw_pkg::side_t        yside;

    logic                  c_vld_reg;
    logic signed [NW-1:0]  c_reg;
    pbw_pkg::side_t        c_side_reg;
    logic                  y_up;
    logic signed [NW-1:0]  c_next;
    logic signed [CW-1:0]  ymin_next;

    logic                  p_vld_reg;
    logic signed [PW-1:0]  prod_reg;
    pbw_pkg::side_t        p_side_reg;

    logic                  d_vld_reg;
    logic signed [DW-1:0]  xd_reg;
    pbw_pkg::side_t        d_side_reg;

    logic                  xv;
    logic [LW-1:0]         rx;
    logic signed [DW-1:0]  qx;
    pbw_pkg::side_t        xside;

    logic signed [CW-1:0]  xmin;
    logic signed [CW+1:0]  x2;
    logic signed [CW+1:0]  lx_s;
    logic signed [CW+1:0]  ly_s;
    logic signed [CW:0]    xfold;
    logic signed [CW-1:0]  xsat;
    logic                  x_out_box;
    logic                  y_out_box;

    logic signed [CW-1:0]  x_res_next;
    logic signed [CW-1:0]  y_res_next;
    logic                  status_next;

    logic                  o_vld_reg;
    logic signed [CW-1:0]  x_res_reg;
    logic signed [CW-1:0]  y_res_reg;
    logic                  status_reg;

    pbw_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en        = !o_vld_reg || dout.ready;
    assign din.ready = en;

    assign lx = (cfg.box_width == '0) ? LW'(1) : cfg.box_width;
    assign ly = (cfg.box_height == '0) ? LW'(1) : cfg.box_height;

    assign side_in.opcode = din.opcode;
    assign side_in.x      = din.x_in;
    assign side_in.y      = din.y_in;
    assign side_in.ymin   = '0;

    // y reduction, floor quotient and remainder
    pbw_fdiv u_ydiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (din.valid),
        .dividend (DW'(din.y_in)),
        .len      (ly),
        .side_in  (side_in),
        .vout     (yv),
        .rem      (ry),
        .quo      (qy),
        .side_out (yside)
    );

    // round half up: remainder at or past half a box goes to the next image
    assign y_up      = {ry, 1'b0} >= {1'b0, ly};
    assign ymin_next = y_up ? $signed(CW'({1'b0, ry}) - CW'({1'b0, ly}))
                            : $signed(CW'({1'b0, ry}));
    assign c_next    = (cfg.bc_mode == pbw_pkg::BC_SHEAR)
                     ? $signed(qy[NW-1:0]) + $signed(NW'(y_up)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= yv;
            p_vld_reg <= c_vld_reg;
            d_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg      <= c_next;
            // reduced y joins the word context here
            c_side_reg <= {yside.opcode, yside.x, yside.y, ymin_next};
            // shear shift of the x image
            prod_reg   <= PW'(cfg.shear_offset) * PW'(c_reg);
            p_side_reg <= c_side_reg;
            xd_reg     <= DW'(p_side_reg.x) - DW'(prod_reg);
            d_side_reg <= p_side_reg;
        end
    end

    // x reduction
    pbw_fdiv u_xdiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vin      (d_vld_reg),
        .dividend (xd_reg),
        .len      (lx),
        .side_in  (d_side_reg),
        .vout     (xv),
        .rem      (rx),
        .quo      (qx),
        .side_out (xside)
    );

    assign xmin = ({rx, 1'b0} >= {1'b0, lx})
                ? $signed(CW'({1'b0, rx}) - CW'({1'b0, lx}))
                : $signed(CW'({1'b0, rx}));

    // bounds tests: outside when 2v < -L or 2v > L
    assign lx_s = $signed({3'b000, lx});
    assign ly_s = $signed({3'b000, ly});
    assign x2   = $signed({xside.x[CW-1], xside.x, 1'b0});

    assign x_out_box = (x2 < -lx_s) || (x2 > lx_s);
    assign y_out_box = ($signed({xside.y[CW-1], xside.y, 1'b0}) < -ly_s)
                    || ($signed({xside.y[CW-1], xside.y, 1'b0}) > ly_s);

    // single fold of x for an x-periodic position, then saturate
    always_comb
    begin
        if (x2 < -lx_s)
        begin
            xfold = (CW+1)'(xside.x) + $signed({2'b00, lx});
        end
        else if (x2 > lx_s)
        begin
            xfold = (CW+1)'(xside.x) - $signed({2'b00, lx});
        end
        else
        begin
            xfold = (CW+1)'(xside.x);
        end

        if (xfold[CW] != xfold[CW-1])
        begin
            xsat = xfold[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            xsat = xfold[CW-1:0];
        end
    end

    always_comb
    begin
        x_res_next  = xmin;
        y_res_next  = xside.ymin;
        status_next = 1'b0;
        unique case (cfg.bc_mode)
            pbw_pkg::BC_PERIODIC, pbw_pkg::BC_SHEAR:
            begin
                x_res_next = xmin;
                y_res_next = xside.ymin;
            end
            pbw_pkg::BC_XPERIODIC:
            begin
                y_res_next = xside.y;
                if (xside.opcode == pbw_pkg::OP_POS)
                begin
                    x_res_next  = xsat;
                    status_next = y_out_box;
                end
            end
            pbw_pkg::BC_OPEN:
            begin
                x_res_next  = xside.x;
                y_res_next  = xside.y;
                status_next = (xside.opcode == pbw_pkg::OP_POS) && (x_out_box || y_out_box);
            end
            default: ;
        endcase
        // an out-of-box position reports zeros
        if (status_next)
        begin
            x_res_next = '0;
            y_res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            o_vld_reg <= xv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_res_reg  <= x_res_next;
            y_res_reg  <= y_res_next;
            status_reg <= status_next && (qx == qx);
        end
    end

    assign dout.valid  = o_vld_reg;
    assign dout.x_out  = x_res_reg;
    assign dout.y_out  = y_res_reg;
    assign dout.status = status_reg;

    `include "periodic_boundary_wrap_assert.svh"

    `PBW_ASSERT_IMP(a_status_zero, dout.valid && dout.status,
        dout.x_out == '0 && dout.y_out == '0, "out-of-box word carries a vector")
    `PBW_ASSERT_IMP(a_status_mode, dout.valid && dout.status,
        cfg.bc_mode == pbw_pkg::BC_XPERIODIC || cfg.bc_mode == pbw_pkg::BC_OPEN,
        "box error in a fully wrapping mode")
    `PBW_ASSERT_NXT(a_stall_hold, o_vld_reg && !dout.ready,
        c_vld_reg == $past(c_vld_reg) && d_vld_reg == $past(d_vld_reg),
        "pipeline moved during an output stall")

endmodule
